[rtl/cis_pkg.sv]
package cis_pkg;

    localparam int CIS_MAX_BODIES   = 64;
    localparam int CIS_MAX_CONTACTS = 128;

    // Q16.16 one
    localparam logic signed [31:0] Q_ONE = 32'sd65536;

    localparam logic [30:0] SLOP_RESET       = 31'd655;
    localparam logic [16:0] CORR_RESET       = 17'd52429;
    localparam logic [30:0] THRESHOLD_RESET  = 31'd65536;
    localparam logic [6:0]  ITERATIONS_RESET = 7'd8;

    // magnitude bits of a Q16.16 dividend scaled up by 16
    localparam int DIV_STEPS = 48;

    typedef enum logic [1:0] {
        REQ_WRITE_BODY    = 2'd0,
        REQ_WRITE_CONTACT = 2'd1,
        REQ_SOLVE         = 2'd2,
        REQ_READ_BODY     = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        CFG_SLOP       = 2'd0,
        CFG_CORRECTION = 2'd1,
        CFG_THRESHOLD  = 2'd2,
        CFG_ITERATIONS = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [7:0]         index;
        logic [5:0]         body_a;
        logic [5:0]         body_b;
        logic signed [31:0] vec_x;
        logic signed [31:0] vec_y;
        logic signed [31:0] aux_x;
        logic signed [31:0] aux_y;
        logic [30:0]        scalar_value;
        logic               flag;
        logic               velocity_present;
    } request_t;

    typedef struct packed {
        logic signed [31:0] out_velocity_x;
        logic signed [31:0] out_velocity_y;
        logic signed [31:0] out_position_x;
        logic signed [31:0] out_position_y;
    } result_t;

    typedef struct packed {
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic [30:0]        inv_mass;
        logic               dynamic;
        logic               has_vel;
    } body_t;

    typedef struct packed {
        logic [5:0]         body_a;
        logic [5:0]         body_b;
        logic signed [31:0] normal_x;
        logic signed [31:0] normal_y;
        logic signed [31:0] depth;
        logic signed [31:0] bounce;
        logic [30:0]        friction;
        logic               sensor;
        logic signed [31:0] normal_acc;
        logic signed [31:0] tangent_acc;
    } contact_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        if (v[47:31] != {17{v[47]}}) begin
            return v[47] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat33($signed({a[31], a}) + $signed({b[31], b}));
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        return sat33($signed({a[31], a}) - $signed({b[31], b}));
    endfunction

    function automatic logic signed [31:0] sat_neg(input logic signed [31:0] a);
        return sat33(-$signed({a[31], a}));
    endfunction

    // Product down by 16 bits, rounded toward zero, saturated.
    function automatic logic signed [31:0] qfix(input logic signed [63:0] p);
        logic signed [47:0] sh;
        sh = p[63:16];
        if (p[63] && (p[15:0] != 16'd0)) begin
            sh = sh + 48'sd1;
        end
        return sat48(sh);
    endfunction

    // Move position or velocity of one body; position needs dynamic,
    // velocity needs dynamic and a velocity.
    function automatic body_t body_move(input body_t b, input logic signed [31:0] dx,
                                        input logic signed [31:0] dy, input logic pos_mode);
        body_t r;
        r = b;
        if (pos_mode) begin
            if (b.dynamic) begin
                r.pos_x = sat_add(b.pos_x, dx);
                r.pos_y = sat_add(b.pos_y, dy);
            end
        end else if (b.dynamic && b.has_vel) begin
            r.vel_x = sat_add(b.vel_x, dx);
            r.vel_y = sat_add(b.vel_y, dy);
        end
        return r;
    endfunction

endpackage

[rtl/cis_divider.sv]
module cis_divider
    import cis_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] dividend,
    input  logic [30:0]        divisor,
    output div_status_t        status,
    output logic signed [31:0] quotient
);

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [31:0]          rem_reg;
    logic [DIV_STEPS-1:0] quo_reg;
    logic [30:0]          den_reg;
    logic                 neg_reg;

    logic [31:0] shifted;
    logic [32:0] trial;
    logic [31:0] mag;

    assign mag     = dividend[31] ? 32'(-dividend) : 32'(dividend);
    assign shifted = {rem_reg[30:0], quo_reg[DIV_STEPS-1]};
    assign trial   = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DIV_STEPS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // restoring division, one quotient bit per cycle
    always_ff @(posedge clk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= {mag, 16'd0};
            den_reg <= divisor;
            neg_reg <= dividend[31];
        end else if (busy_reg) begin
            if (!trial[32]) begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b1};
            end else begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[DIV_STEPS-2:0], 1'b0};
            end
        end
    end

    always_comb begin
        if (neg_reg) begin
            if (quo_reg > DIV_STEPS'(33'h0_8000_0000)) begin
                quotient = 32'sh8000_0000;
            end else begin
                quotient = 32'(-quo_reg);
            end
        end else if (quo_reg > DIV_STEPS'(32'h7FFF_FFFF)) begin
            quotient = 32'sh7FFF_FFFF;
        end else begin
            quotient = 32'(quo_reg);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

[rtl/contact_impulse_solver_2d.sv]
// 2D sequential-impulse contact solver over a body table and a contact table.
// Requests arrive on req (valid/ready), one at a time; each produces exactly
// one result on rsp (valid/ready). req_ready is high only while the sequencer
// is idle, so a new request may be taken while the previous result still sits
// in the output register waiting for rsp_ready.
// Request kinds: write body, write contact (clears both accumulated impulses),
// solve over the first index contacts, read body (velocity and position).
// Writes and reads: accept, execute state, response state, then rsp_valid.
// Solve: one position pass then iteration_count velocity passes. Each usable
// contact in either pass goes through the shared bit-serial divider (one
// quotient in the position step, up to two in the velocity step) and a
// read-modify-write of the body and contact memories, each with one read
// and one write port. Skipped contacts return to the contact read without
// a write-back.
// Configuration writes on cfg (always ready) take effect at once; write them
// only while the block is idle.
// Reset clears the sequencer and the output valid and loads the configuration
// defaults; table contents are undefined until written; no clearing pass runs.
// A stalled receiver holds the result register; the sequencer then waits in
// its response state and takes no new request.
module contact_impulse_solver_2d
    import cis_pkg::*;
#(
    parameter int MAX_BODIES   = CIS_MAX_BODIES,
    parameter int MAX_CONTACTS = CIS_MAX_CONTACTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  request_t    req,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output result_t     rsp,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int BAW = $clog2(MAX_BODIES);
    localparam int CAW = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CW  = $clog2(MAX_CONTACTS + 1);

    typedef enum logic [35:0] {
        S_IDLE  = 36'd1 << 0,
        S_EXEC  = 36'd1 << 1,
        S_RESP  = 36'd1 << 2,
        S_CREAD = 36'd1 << 3,
        S_CLOAD = 36'd1 << 4,
        S_BRDA  = 36'd1 << 5,
        S_BRDB  = 36'd1 << 6,
        S_CHK   = 36'd1 << 7,
        S_POS0  = 36'd1 << 8,
        S_POS1  = 36'd1 << 9,
        S_POS2  = 36'd1 << 10,
        S_V0    = 36'd1 << 11,
        S_V1    = 36'd1 << 12,
        S_V2    = 36'd1 << 13,
        S_V3    = 36'd1 << 14,
        S_V4    = 36'd1 << 15,
        S_V5    = 36'd1 << 16,
        S_V6    = 36'd1 << 17,
        S_V7    = 36'd1 << 18,
        S_V8    = 36'd1 << 19,
        S_V9    = 36'd1 << 20,
        S_V10   = 36'd1 << 21,
        S_V11   = 36'd1 << 22,
        S_V12   = 36'd1 << 23,
        S_V13   = 36'd1 << 24,
        S_V14   = 36'd1 << 25,
        S_V15   = 36'd1 << 26,
        S_U0    = 36'd1 << 27,
        S_U1    = 36'd1 << 28,
        S_U2    = 36'd1 << 29,
        S_U3    = 36'd1 << 30,
        S_U4    = 36'd1 << 31,
        S_U5    = 36'd1 << 32,
        S_U6    = 36'd1 << 33,
        S_WBA   = 36'd1 << 34,
        S_WBB   = 36'd1 << 35
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [30:0] slop_reg;
    logic [16:0] corr_reg;
    logic [30:0] thr_reg;
    logic [6:0]  iter_reg;

    // sequencer and datapath registers
    request_t           req_reg;
    result_t            rsp_reg;
    logic               rsp_valid_reg;
    logic [CW-1:0]      cidx_reg;
    logic [CW-1:0]      count_reg;
    logic [6:0]         it_reg;
    logic               phase_vel_reg;
    contact_t           con_reg;
    body_t              ba_reg, bb_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] rx_reg, ry_reg, t0_reg, rn_reg, lam_reg, tl_reg, lim_reg;
    logic signed [31:0] delta_reg, dir_x_reg, dir_y_reg;
    logic signed [31:0] px_reg, py_reg, ax_reg, bx_reg;
    logic               pos_mode_reg;
    state_t             ret_reg;

    // memories
    body_t    bmem [MAX_BODIES];
    contact_t cmem [MAX_CONTACTS];
    body_t    bmem_q;
    contact_t cmem_q;
    logic           b_we, c_we;
    logic [BAW-1:0] b_waddr, b_raddr;
    logic [CAW-1:0] c_waddr, c_raddr;
    body_t          b_wdata;
    contact_t       c_wdata;

    // divider
    logic               div_start;
    logic signed [31:0] div_dividend;
    div_status_t        div_status;
    logic signed [31:0] div_quot;

    // combinational datapath
    logic signed [31:0] mul_a, mul_b, qf;
    logic signed [31:0] vax, vay, vbx, vby, ima, imb, pair_sum;
    logic signed [31:0] excess, e_val, onee, tx, newn;
    logic signed [32:0] newt_wide, lim_wide;
    logic signed [31:0] newt;
    logic               same_body, contact_skip, pass_last, body_ok, contact_ok;
    logic               rsp_free;
    body_t              new_a, new_b, req_body;
    contact_t           req_contact;

    assign req_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;

    assign body_ok    = 32'(req_reg.index) < MAX_BODIES;
    assign contact_ok = 32'(req_reg.index) < MAX_CONTACTS;

    assign vax = ba_reg.has_vel ? ba_reg.vel_x : 32'sd0;
    assign vay = ba_reg.has_vel ? ba_reg.vel_y : 32'sd0;
    assign vbx = bb_reg.has_vel ? bb_reg.vel_x : 32'sd0;
    assign vby = bb_reg.has_vel ? bb_reg.vel_y : 32'sd0;
    assign ima = ba_reg.dynamic ? $signed({1'b0, ba_reg.inv_mass}) : 32'sd0;
    assign imb = bb_reg.dynamic ? $signed({1'b0, bb_reg.inv_mass}) : 32'sd0;
    assign pair_sum  = sat_add(ima, imb);
    assign same_body = (con_reg.body_a == con_reg.body_b);

    assign contact_skip = cmem_q.sensor || (32'(cmem_q.body_a) >= MAX_BODIES) ||
                          (32'(cmem_q.body_b) >= MAX_BODIES);
    assign pass_last = ({1'b0, it_reg} + 8'd1) >= {1'b0, iter_reg};

    assign qf     = qfix(prod_reg);
    assign excess = sat_sub(con_reg.depth, $signed({1'b0, slop_reg}));
    assign e_val  = ($signed({rn_reg[31], rn_reg}) < -$signed({2'b00, thr_reg})) ?
                    con_reg.bounce : 32'sd0;
    assign onee   = sat_add(Q_ONE, e_val);
    assign tx     = sat_neg(con_reg.normal_y);

    always_comb begin
        newn = sat_add(con_reg.normal_acc, lam_reg);
        if (newn[31]) begin
            newn = 32'sd0;
        end
    end

    // clamp the new tangent impulse to the friction cone
    always_comb begin
        newt_wide = $signed({con_reg.tangent_acc[31], con_reg.tangent_acc}) +
                    $signed({tl_reg[31], tl_reg});
        lim_wide  = $signed({lim_reg[31], lim_reg});
        if (newt_wide > lim_wide) begin
            newt = lim_reg;
        end else if (newt_wide < -lim_wide) begin
            newt = -lim_reg;
        end else begin
            newt = newt_wide[31:0];
        end
    end

    assign new_a = body_move(ba_reg, ax_reg, sat_neg(qf), pos_mode_reg);
    assign new_b = body_move(bb_reg, bx_reg, qf, pos_mode_reg);

    // shared multiplier operands
    always_comb begin
        mul_a = 32'sd0;
        mul_b = 32'sd0;
        unique case (state_reg)
            S_POS0: begin mul_a = excess;     mul_b = $signed({15'd0, corr_reg}); end
            S_U0:   begin mul_a = dir_x_reg;  mul_b = delta_reg; end
            S_U1:   begin mul_a = dir_y_reg;  mul_b = delta_reg; end
            S_U2:   begin mul_a = px_reg;     mul_b = ima; end
            S_U3:   begin mul_a = py_reg;     mul_b = ima; end
            S_U4:   begin mul_a = px_reg;     mul_b = imb; end
            S_U5:   begin mul_a = py_reg;     mul_b = imb; end
            S_V1:   begin mul_a = rx_reg;     mul_b = con_reg.normal_x; end
            S_V2:   begin mul_a = ry_reg;     mul_b = con_reg.normal_y; end
            S_V4:   begin mul_a = onee;       mul_b = rn_reg; end
            S_V9:   begin mul_a = rx_reg;     mul_b = tx; end
            S_V10:  begin mul_a = ry_reg;     mul_b = con_reg.normal_x; end
            S_V12:  begin
                mul_a = $signed({1'b0, con_reg.friction});
                mul_b = con_reg.normal_acc;
            end
            default: ;
        endcase
    end

    // divider hookup
    always_comb begin
        div_start    = 1'b0;
        div_dividend = qf;
        unique case (state_reg)
            S_POS1: begin div_start = 1'b1; div_dividend = qf; end
            S_V5:   begin div_start = 1'b1; div_dividend = sat_neg(qf); end
            S_V11:  begin div_start = 1'b1; div_dividend = sat_add(t0_reg, qf); end
            default: ;
        endcase
    end

    cis_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (pair_sum[30:0]),
        .status   (div_status),
        .quotient (div_quot)
    );

    // memory ports
    always_comb begin
        req_body.vel_x    = req_reg.vec_x;
        req_body.vel_y    = req_reg.vec_y;
        req_body.pos_x    = req_reg.aux_x;
        req_body.pos_y    = req_reg.aux_y;
        req_body.inv_mass = req_reg.scalar_value;
        req_body.dynamic  = req_reg.flag;
        req_body.has_vel  = req_reg.velocity_present;

        req_contact.body_a      = req_reg.body_a;
        req_contact.body_b      = req_reg.body_b;
        req_contact.normal_x    = req_reg.vec_x;
        req_contact.normal_y    = req_reg.vec_y;
        req_contact.depth       = req_reg.aux_x;
        req_contact.bounce      = req_reg.aux_y;
        req_contact.friction    = req_reg.scalar_value;
        req_contact.sensor      = req_reg.flag;
        req_contact.normal_acc  = 32'sd0;
        req_contact.tangent_acc = 32'sd0;

        b_we    = 1'b0;
        b_waddr = BAW'(req_reg.index);
        b_wdata = req_body;
        c_we    = 1'b0;
        c_waddr = CAW'(req_reg.index);
        c_wdata = req_contact;

        if (state_reg == S_EXEC) begin
            b_we = (req_reg.req_type == REQ_WRITE_BODY) && body_ok;
            c_we = (req_reg.req_type == REQ_WRITE_CONTACT) && contact_ok;
        end else if (state_reg == S_WBA) begin
            b_we    = 1'b1;
            b_waddr = BAW'(con_reg.body_a);
            b_wdata = ba_reg;
            c_we    = 1'b1;
            c_waddr = CAW'(cidx_reg);
            c_wdata = con_reg;
        end else if (state_reg == S_WBB) begin
            b_we    = 1'b1;
            b_waddr = BAW'(con_reg.body_b);
            b_wdata = bb_reg;
        end

        if (state_reg == S_CLOAD) begin
            b_raddr = BAW'(cmem_q.body_a);
        end else if (state_reg == S_BRDA) begin
            b_raddr = BAW'(con_reg.body_b);
        end else begin
            b_raddr = BAW'(req_reg.index);
        end
        c_raddr = CAW'(cidx_reg);
    end

    always_ff @(posedge clk) begin
        if (b_we) begin
            bmem[b_waddr] <= b_wdata;
        end
        bmem_q <= bmem[b_raddr];
    end

    always_ff @(posedge clk) begin
        if (c_we) begin
            cmem[c_waddr] <= c_wdata;
        end
        cmem_q <= cmem[c_raddr];
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (req_valid) state_next = S_EXEC;
            S_EXEC:  state_next = (req_reg.req_type == REQ_SOLVE) ? S_CREAD : S_RESP;
            S_RESP:  if (rsp_free) state_next = S_IDLE;
            S_CREAD: begin
                if (cidx_reg == count_reg) begin
                    if (!phase_vel_reg) begin
                        state_next = (iter_reg == 7'd0) ? S_RESP : S_CREAD;
                    end else begin
                        state_next = pass_last ? S_RESP : S_CREAD;
                    end
                end else begin
                    state_next = S_CLOAD;
                end
            end
            S_CLOAD: state_next = contact_skip ? S_CREAD : S_BRDA;
            S_BRDA:  state_next = S_BRDB;
            S_BRDB:  state_next = S_CHK;
            S_CHK: begin
                if (pair_sum <= 32'sd0) begin
                    state_next = S_CREAD;
                end else begin
                    state_next = phase_vel_reg ? S_V0 : S_POS0;
                end
            end
            S_POS0:  state_next = (excess <= 32'sd0) ? S_CREAD : S_POS1;
            S_POS1:  state_next = S_POS2;
            S_POS2:  if (div_status.done) state_next = S_U0;
            S_V0:    state_next = S_V1;
            S_V1:    state_next = S_V2;
            S_V2:    state_next = S_V3;
            S_V3:    state_next = S_V4;
            S_V4:    state_next = (rn_reg > 32'sd0) ? S_V7 : S_V5;
            S_V5:    state_next = S_V6;
            S_V6:    if (div_status.done) state_next = S_V7;
            S_V7:    state_next = S_U0;
            S_V8:    state_next = S_V9;
            S_V9:    state_next = S_V10;
            S_V10:   state_next = S_V11;
            S_V11:   state_next = S_V12;
            S_V12:   if (div_status.done) state_next = S_V13;
            S_V13:   state_next = S_V14;
            S_V14:   state_next = S_V15;
            S_V15:   state_next = S_U0;
            S_U0:    state_next = S_U1;
            S_U1:    state_next = S_U2;
            S_U2:    state_next = S_U3;
            S_U3:    state_next = S_U4;
            S_U4:    state_next = S_U5;
            S_U5:    state_next = S_U6;
            S_U6:    state_next = ret_reg;
            S_WBA:   state_next = S_WBB;
            S_WBB:   state_next = S_CREAD;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
            slop_reg      <= SLOP_RESET;
            corr_reg      <= CORR_RESET;
            thr_reg       <= THRESHOLD_RESET;
            iter_reg      <= ITERATIONS_RESET;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_RESP && rsp_free) begin
                rsp_valid_reg <= 1'b1;
            end else if (rsp_ready) begin
                rsp_valid_reg <= 1'b0;
            end
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_SLOP:       slop_reg <= cfg_data[30:0];
                    CFG_CORRECTION: corr_reg <= cfg_data[16:0];
                    CFG_THRESHOLD:  thr_reg  <= cfg_data[30:0];
                    CFG_ITERATIONS: iter_reg <= cfg_data[6:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk) begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE: if (req_valid) req_reg <= req;
            S_EXEC: begin
                cidx_reg      <= '0;
                it_reg        <= '0;
                phase_vel_reg <= 1'b0;
                count_reg     <= (32'(req_reg.index) > MAX_CONTACTS) ?
                                 CW'(MAX_CONTACTS) : CW'(req_reg.index);
            end
            S_RESP: begin
                if (rsp_free) begin
                    if (req_reg.req_type == REQ_READ_BODY && body_ok) begin
                        rsp_reg.out_velocity_x <= bmem_q.vel_x;
                        rsp_reg.out_velocity_y <= bmem_q.vel_y;
                        rsp_reg.out_position_x <= bmem_q.pos_x;
                        rsp_reg.out_position_y <= bmem_q.pos_y;
                    end else begin
                        rsp_reg <= '0;
                    end
                end
            end
            S_CREAD: begin
                // end of a pass: rewind the contact index, advance the pass
                if (cidx_reg == count_reg) begin
                    cidx_reg <= '0;
                    if (!phase_vel_reg) begin
                        phase_vel_reg <= 1'b1;
                        it_reg        <= '0;
                    end else begin
                        it_reg <= it_reg + 7'd1;
                    end
                end
            end
            S_CLOAD: begin
                con_reg <= cmem_q;
                if (contact_skip) cidx_reg <= cidx_reg + CW'(1);
            end
            S_BRDA: ba_reg <= bmem_q;
            S_BRDB: bb_reg <= bmem_q;
            S_CHK:  if (pair_sum <= 32'sd0) cidx_reg <= cidx_reg + CW'(1);
            S_POS0: if (excess <= 32'sd0) cidx_reg <= cidx_reg + CW'(1);
            S_POS1: ;
            S_POS2: begin
                if (div_status.done) begin
                    delta_reg    <= div_quot;
                    dir_x_reg    <= con_reg.normal_x;
                    dir_y_reg    <= con_reg.normal_y;
                    pos_mode_reg <= 1'b1;
                    ret_reg      <= S_WBA;
                end
            end
            S_V0, S_V8: begin
                rx_reg <= sat_sub(vbx, vax);
                ry_reg <= sat_sub(vby, vay);
            end
            S_V1:  ;
            S_V2:  t0_reg <= qf;
            S_V3:  rn_reg <= sat_add(t0_reg, qf);
            S_V4:  if (rn_reg > 32'sd0) lam_reg <= 32'sd0;
            S_V5:  ;
            S_V6:  if (div_status.done) lam_reg <= div_quot;
            S_V7: begin
                con_reg.normal_acc <= newn;
                delta_reg          <= sat_sub(newn, con_reg.normal_acc);
                dir_x_reg          <= con_reg.normal_x;
                dir_y_reg          <= con_reg.normal_y;
                pos_mode_reg       <= 1'b0;
                ret_reg            <= S_V8;
            end
            S_V9:  ;
            S_V10: t0_reg <= qf;
            S_V11: ;
            S_V12: if (div_status.done) tl_reg <= sat_neg(div_quot);
            S_V13: lim_reg <= qf[31] ? 32'sd0 : qf;
            S_V14: t0_reg <= newt;
            S_V15: begin
                con_reg.tangent_acc <= t0_reg;
                delta_reg           <= sat_sub(t0_reg, con_reg.tangent_acc);
                dir_x_reg           <= tx;
                dir_y_reg           <= con_reg.normal_x;
                pos_mode_reg        <= 1'b0;
                ret_reg             <= S_WBA;
            end
            S_U0: ;
            S_U1: px_reg <= qf;
            S_U2: py_reg <= qf;
            S_U3: ax_reg <= sat_neg(qf);
            S_U4: begin
                // same body on both sides: forward the first update
                ba_reg <= new_a;
                if (same_body) bb_reg <= new_a;
            end
            S_U5: bx_reg <= qf;
            S_U6: begin
                bb_reg <= new_b;
                if (same_body) ba_reg <= new_b;
            end
            S_WBA: ;
            S_WBB: cidx_reg <= cidx_reg + CW'(1);
            default: ;
        endcase
    end

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_status.busy)
        else $error("divider started while busy");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && rsp_valid_reg && !rsp_ready) |=> (state_reg == S_RESP))
        else $error("result overwritten while receiver stalls");

    a_ids_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WBA) |->
        (32'(con_reg.body_a) < MAX_BODIES && 32'(con_reg.body_b) < MAX_BODIES))
        else $error("write back to a body id out of range");

    a_nacc_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WBA && phase_vel_reg) |-> !con_reg.normal_acc[31])
        else $error("negative accumulated normal impulse");

    a_tacc_cone: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WBA && phase_vel_reg) |->
        (con_reg.tangent_acc <= lim_reg && con_reg.tangent_acc >= -lim_reg))
        else $error("tangent impulse outside friction limit");

endmodule
